// ===== rtl/cprs_pkg.sv =====
// Shared constants, types and helpers for the closest-point-on-segment pipeline.
package cprs_pkg;

    // Number of CORDIC micro-rotations in each rotator.
    localparam int ROTATE_STAGES = 16;
    localparam int MAX_STAGES    = 24;
    // Extra fraction bits carried through the rotators.
    localparam int GUARD         = 8;
    // Width of a rotator input operand and of the CORDIC datapath.
    localparam int ROT_IN_W      = 34;
    localparam int CW            = 44;
    localparam int ZW            = 34;
    // CORDIC gain compensation, Q30.
    localparam logic signed [31:0] KGAIN = 32'sd652032874;
    localparam int MUL_SHIFT     = 30 - GUARD;

    // Arctangent table in units of 2^-32 turn.
    localparam logic signed [ZW-1:0] ATAN_TAB [0:MAX_STAGES-1] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
        34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
        34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
        34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
        34'sd652, 34'sd326, 34'sd163, 34'sd81
    };

    // Pipeline depths.
    localparam int ROT_LAT     = ROTATE_STAGES + 2;
    localparam int SQRT_STAGES = 32;
    localparam int SIDE_DLY    = SQRT_STAGES + 2;
    localparam int BACK_DLY    = SIDE_DLY - ROT_LAT;
    localparam int PIPE_LAT    = ROT_LAT + SQRT_STAGES + 6;

    // Fields that ride alongside the geometry.
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [15:0] ang;
        logic [30:0] len;
    } t_fwd;

    // Saturate a widened sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
        logic signed [31:0] res;
        if (v > 45'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -45'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/closest_point_on_rotated_segment.sv =====
// Depth: PIPE_LAT (56) register stages with 16 rotator stages. Throughput: one item per
// cycle; the whole pipeline advances whenever the output register is empty or its result
// is taken in the same cycle.
// The depth is set by the forward CORDIC rotator and the 32-stage square root.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module closest_point_on_rotated_segment import cprs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // center_x, center_y, center_z, seg_length, seg_angle, point_x, point_y, pad
    input  logic [207:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // distance, proj_x, proj_y, proj_z
    output logic [127:0] o_m_axis_tdata
);

    logic                       w_en;
    logic                       r_vld [0:PIPE_LAT-1];
    t_fwd                       n_fwd;
    t_fwd                       r_fwd [0:ROT_LAT+2];
    logic signed [ROT_IN_W-1:0] r_dx;
    logic signed [ROT_IN_W-1:0] r_dy;
    logic signed [CW-1:0]       w_rx;
    logic signed [CW-1:0]       w_ry;
    logic signed [45:0]         n_h;
    logic signed [45:0]         n_rx;
    logic signed [45:0]         n_lx;
    logic signed [45:0]         r_lx;
    logic signed [45:0]         r_rx;
    logic signed [CW-1:0]       r_ry;
    logic signed [46:0]         n_ex;
    logic signed [46:0]         n_ey;
    logic signed [46:0]         n_ea;
    logic signed [46:0]         n_eb;
    logic signed [45:0]         n_lxr;
    logic [31:0]                r_a;
    logic [31:0]                r_b;
    logic                       r_big;
    logic signed [ROT_IN_W-1:0] r_lxr;
    logic [63:0]                r_a2;
    logic [63:0]                r_b2;
    logic                       r_big2;
    logic [64:0]                n_s;
    logic [63:0]                r_s;
    logic                       r_ovf;
    logic [31:0]                w_root;
    logic [32:0]                w_rem;
    logic                       w_sq_ovf;
    logic signed [CW-1:0]       w_gx;
    logic signed [CW-1:0]       w_gy;
    logic signed [CW-1:0]       r_gx [0:BACK_DLY-1];
    logic signed [CW-1:0]       r_gy [0:BACK_DLY-1];
    t_side                      r_side [0:SIDE_DLY-1];
    logic [32:0]                n_d;
    logic signed [CW-1:0]       n_gxr;
    logic signed [CW-1:0]       n_gyr;
    t_side                      w_side_o;
    logic [31:0]                r_dist;
    logic signed [31:0]         r_px;
    logic signed [31:0]         r_py;
    logic signed [31:0]         r_pz;

    // Global advance: move when the output slot frees up this cycle.
    assign w_en            = !r_vld[PIPE_LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[PIPE_LAT-1];
    assign o_m_axis_tdata  = {r_pz, r_py, r_px, r_dist};

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Input stage: offset of the point from the center.
    assign n_fwd.side.cx = i_s_axis_tdata[31:0];
    assign n_fwd.side.cy = i_s_axis_tdata[63:32];
    assign n_fwd.side.cz = i_s_axis_tdata[95:64];
    assign n_fwd.len     = i_s_axis_tdata[126:96];
    assign n_fwd.ang     = i_s_axis_tdata[142:127];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= ROT_IN_W'(signed'(i_s_axis_tdata[174:143]))
                  - ROT_IN_W'(signed'(i_s_axis_tdata[31:0]));
            r_dy <= ROT_IN_W'(signed'(i_s_axis_tdata[206:175]))
                  - ROT_IN_W'(signed'(i_s_axis_tdata[63:32]));
            r_fwd[0] <= n_fwd;
            for (int i = 1; i <= ROT_LAT + 2; i++) begin
                r_fwd[i] <= r_fwd[i-1];
            end
        end
    end

    // Rotate the offset into the segment frame.
    cprs_rot u_rot_fwd (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_dx),
        .i_y   (r_dy),
        .i_t   (16'd0 - r_fwd[0].ang),
        .o_x   (w_rx),
        .o_y   (w_ry)
    );

    // Clamp the along-axis coordinate to the half length.
    assign n_h  = {8'd0, r_fwd[ROT_LAT].len, 7'd0};
    assign n_rx = 46'(w_rx);

    always_comb begin
        if (n_rx > -n_h && n_rx < n_h) begin
            n_lx = n_rx;
        end else if (n_rx > 46'sd0) begin
            n_lx = n_h;
        end else if (n_rx < 46'sd0) begin
            n_lx = -n_h;
        end else begin
            n_lx = 46'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lx <= n_lx;
            r_rx <= n_rx;
            r_ry <= w_ry;
        end
    end

    // Error vector rounded to whole units, magnitudes and range check.
    assign n_ex  = (47'(r_lx) - 47'(r_rx) + 47'sd128) >>> GUARD;
    assign n_ey  = (-47'(r_ry) + 47'sd128) >>> GUARD;
    assign n_ea  = n_ex[46] ? -n_ex : n_ex;
    assign n_eb  = n_ey[46] ? -n_ey : n_ey;
    assign n_lxr = (r_lx + 46'sd128) >>> GUARD;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a   <= n_ea[31:0];
            r_b   <= n_eb[31:0];
            r_big <= (n_ea[46:32] != 15'd0) || (n_eb[46:32] != 15'd0);
            r_lxr <= n_lxr[ROT_IN_W-1:0];
        end
    end

    // Squares, then their sum.
    assign n_s = 65'(r_a2) + 65'(r_b2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a2   <= 64'(r_a) * 64'(r_a);
            r_b2   <= 64'(r_b) * 64'(r_b);
            r_big2 <= r_big;
            r_s    <= n_s[63:0];
            r_ovf  <= r_big2 || n_s[64];
        end
    end

    cprs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_s),
        .i_flag (r_ovf),
        .o_root (w_root),
        .o_rem  (w_rem),
        .o_flag (w_sq_ovf)
    );

    // Rotate the clamped point back into world orientation.
    cprs_rot u_rot_back (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_lxr),
        .i_y   ({ROT_IN_W{1'b0}}),
        .i_t   (r_fwd[ROT_LAT+2].ang),
        .o_x   (w_gx),
        .o_y   (w_gy)
    );

    // Align the back rotation and the center with the root.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gx[0]   <= w_gx;
            r_gy[0]   <= w_gy;
            r_side[0] <= r_fwd[ROT_LAT+2].side;
            for (int i = 1; i < BACK_DLY; i++) begin
                r_gx[i] <= r_gx[i-1];
                r_gy[i] <= r_gy[i-1];
            end
            for (int i = 1; i < SIDE_DLY; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Output stage: round the root, add the center and saturate.
    assign w_side_o = r_side[SIDE_DLY-1];
    assign n_d      = 33'(w_root) + 33'(w_rem > 33'(w_root));
    assign n_gxr    = (r_gx[BACK_DLY-1] + 44'sd128) >>> GUARD;
    assign n_gyr    = (r_gy[BACK_DLY-1] + 44'sd128) >>> GUARD;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dist <= (w_sq_ovf || n_d[32]) ? 32'hFFFFFFFF : n_d[31:0];
            r_px   <= sat32(45'(w_side_o.cx) + 45'(n_gxr));
            r_py   <= sat32(45'(w_side_o.cy) + 45'(n_gyr));
            r_pz   <= w_side_o.cz;
        end
    end

`ifndef SYNTHESIS
    // A held result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // Input is refused only behind a waiting result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input refused without a stalled output");

    // An overflowing sum of squares saturates the distance.
    a_dist_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[PIPE_LAT-2] && w_sq_ovf) |=> (o_m_axis_tdata[31:0] == 32'hFFFFFFFF))
        else $error("distance not saturated on overflow");
`endif

endmodule

// ===== rtl/cprs_rot.sv =====
// Pipelined CORDIC rotator with gain compensation and quadrant fold.
module cprs_rot import cprs_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [ROT_IN_W-1:0] i_x,
    input  logic signed [ROT_IN_W-1:0] i_y,
    input  logic [15:0]                i_t,
    output logic signed [CW-1:0]       o_x,
    output logic signed [CW-1:0]       o_y
);

    logic signed [63:0]   r_mx;
    logic signed [63:0]   r_my;
    logic [15:0]          r_t;
    logic signed [63:0]   n_mxr;
    logic signed [63:0]   n_myr;
    logic [15:0]          n_tq;
    logic [15:0]          n_t2;
    logic signed [CW-1:0] r_xs [0:ROTATE_STAGES];
    logic signed [CW-1:0] r_ys [0:ROTATE_STAGES];
    logic signed [ZW-1:0] r_zs [0:ROTATE_STAGES];

    // Gain compensation multiply.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx <= i_x * KGAIN;
            r_my <= i_y * KGAIN;
            r_t  <= i_t;
        end
    end

    // Round into the guard format and fold the angle into the right half plane.
    assign n_mxr = (r_mx + (64'sd1 <<< (MUL_SHIFT - 1))) >>> MUL_SHIFT;
    assign n_myr = (r_my + (64'sd1 <<< (MUL_SHIFT - 1))) >>> MUL_SHIFT;
    assign n_tq  = r_t + 16'd16384;
    assign n_t2  = {r_t[15] ^ n_tq[15], r_t[14:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xs[0] <= n_tq[15] ? -n_mxr[CW-1:0] : n_mxr[CW-1:0];
            r_ys[0] <= n_tq[15] ? -n_myr[CW-1:0] : n_myr[CW-1:0];
            r_zs[0] <= {{(ZW-32){n_t2[15]}}, n_t2, 16'd0};
        end
    end

    // One micro-rotation per stage.
    for (genvar g = 0; g < ROTATE_STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_zs[g][ZW-1]) begin
                    r_xs[g+1] <= r_xs[g] - (r_ys[g] >>> g);
                    r_ys[g+1] <= r_ys[g] + (r_xs[g] >>> g);
                    r_zs[g+1] <= r_zs[g] - ATAN_TAB[g];
                end else begin
                    r_xs[g+1] <= r_xs[g] + (r_ys[g] >>> g);
                    r_ys[g+1] <= r_ys[g] - (r_xs[g] >>> g);
                    r_zs[g+1] <= r_zs[g] + ATAN_TAB[g];
                end
            end
        end
    end

    assign o_x = r_xs[ROTATE_STAGES];
    assign o_y = r_ys[ROTATE_STAGES];

endmodule

// ===== rtl/cprs_sqrt.sv =====
// Pipelined integer square root with remainder, one result bit per stage.
module cprs_sqrt import cprs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    input  logic        i_flag,
    output logic [31:0] o_root,
    output logic [32:0] o_rem,
    output logic        o_flag
);

    logic [63:0] r_rm [0:SQRT_STAGES-1];
    logic [31:0] r_q  [0:SQRT_STAGES-1];
    logic        r_fl [0:SQRT_STAGES-1];

    // Stage g decides root bit 31-g.
    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_bit
        localparam int K = SQRT_STAGES - 1 - g;
        logic [63:0] w_rm_in;
        logic [31:0] w_q_in;
        logic        w_fl_in;
        logic [65:0] w_trial;
        logic        w_ge;

        if (g == 0) begin : g_first
            assign w_rm_in = i_rad;
            assign w_q_in  = 32'd0;
            assign w_fl_in = i_flag;
        end else begin : g_next
            assign w_rm_in = r_rm[g-1];
            assign w_q_in  = r_q[g-1];
            assign w_fl_in = r_fl[g-1];
        end

        assign w_trial = (66'(w_q_in) << (K + 1)) + (66'd1 << (2 * K));
        assign w_ge    = {2'b00, w_rm_in} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rm[g] <= w_ge ? (w_rm_in - w_trial[63:0]) : w_rm_in;
                r_q[g]  <= w_ge ? (w_q_in | (32'd1 << K)) : w_q_in;
                r_fl[g] <= w_fl_in;
            end
        end
    end

    assign o_root = r_q[SQRT_STAGES-1];
    assign o_rem  = r_rm[SQRT_STAGES-1][32:0];
    assign o_flag = r_fl[SQRT_STAGES-1];

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the closest-point-on-rotated-segment pipeline, with its scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import cprs_pkg::*;

    // One geometry query as it travels on the slave side.
    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        len;
        logic [15:0]        ang;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_query;

    // One closest-point answer.
    typedef struct {
        logic [31:0] distance;
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qz;
    } t_answer;

    // Predicts closest-point answers and matches them in order.
    class closest_point_board;
        t_answer pending[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        static function longint fshr(longint v, int s);
            return v >>> s;
        endfunction

        static function longint rshr(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        // Gain-compensated CORDIC rotation; results carry GUARD fraction bits.
        static function void rotate_vec(input longint x0, input longint y0,
                                        input logic [15:0] t0,
                                        output longint ox, output longint oy);
            longint      x;
            longint      y;
            longint      nx;
            longint      ny;
            longint      z;
            logic [15:0] t;
            x = rshr(x0 * longint'(KGAIN), MUL_SHIFT);
            y = rshr(y0 * longint'(KGAIN), MUL_SHIFT);
            t = t0;
            // Fold the angle into the half turn around zero.
            if (16'(t + 16'd16384) >= 16'd32768) begin
                x = -x;
                y = -y;
                t = t + 16'd32768;
            end
            z = longint'($signed(t)) * 65536;
            for (int i = 0; i < ROTATE_STAGES && i < MAX_STAGES; i++) begin
                if (z >= 0) begin
                    nx = x - fshr(y, i);
                    ny = y + fshr(x, i);
                    z  = z - longint'(ATAN_TAB[i]);
                end else begin
                    nx = x + fshr(y, i);
                    ny = y - fshr(x, i);
                    z  = z + longint'(ATAN_TAB[i]);
                end
                x = nx;
                y = ny;
            end
            ox = x;
            oy = y;
        endfunction

        static function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Rounded square root of a sum of two squares, saturating.
        static function logic [31:0] hypot_round(longint ex, longint ey);
            longint unsigned a;
            longint unsigned b;
            logic [64:0]     s65;
            longint unsigned s;
            longint unsigned r;
            longint unsigned bt;
            a = (ex < 0) ? longint'(-ex) : ex;
            b = (ey < 0) ? longint'(-ey) : ey;
            if (a >= 64'h1_0000_0000 || b >= 64'h1_0000_0000) return 32'hFFFF_FFFF;
            s65 = {1'b0, a * a} + {1'b0, b * b};
            if (s65[64]) return 32'hFFFF_FFFF;
            s  = s65[63:0];
            r  = 0;
            bt = 64'h4000_0000_0000_0000;
            while (bt > s) bt = bt >> 2;
            while (bt != 0) begin
                if (s >= r + bt) begin
                    s = s - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
            // Round to nearest using the remainder.
            if (s > r) r = r + 1;
            if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
            return r[31:0];
        endfunction

        // Note an accepted query and queue its expected answer.
        function void note_query(t_query q);
            longint  rx;
            longint  ry;
            longint  lx;
            longint  hl;
            longint  gx;
            longint  gy;
            t_answer e;
            rotate_vec(longint'(q.px) - longint'(q.cx), longint'(q.py) - longint'(q.cy),
                       16'(17'h10000 - q.ang), rx, ry);
            hl = longint'(q.len) <<< (GUARD - 1);
            if (rx > -hl && rx < hl) lx = rx;
            else if (rx > 0) lx = hl;
            else if (rx < 0) lx = -hl;
            else lx = 0;
            e.distance = hypot_round(rshr(lx - rx, GUARD), rshr(-ry, GUARD));
            rotate_vec(rshr(lx, GUARD), 0, q.ang, gx, gy);
            e.qx = 32'(clip32(longint'(q.cx) + rshr(gx, GUARD)));
            e.qy = 32'(clip32(longint'(q.cy) + rshr(gy, GUARD)));
            e.qz = q.cz;
            pending.push_back(e);
        endfunction

        // Compare an accepted answer with the oldest expectation.
        function void check_answer(t_answer a);
            t_answer e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected answer distance=%h x=%h y=%h z=%h",
                         $time, a.distance, a.qx, a.qy, a.qz);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.distance !== e.distance) begin
                $display("%0t: distance expected %h actual %h", $time, e.distance,
                         a.distance);
                errors++;
            end
            if (a.qx !== e.qx) begin
                $display("%0t: proj_x expected %h actual %h", $time, e.qx, a.qx);
                errors++;
            end
            if (a.qy !== e.qy) begin
                $display("%0t: proj_y expected %h actual %h", $time, e.qy, a.qy);
                errors++;
            end
            if (a.qz !== e.qz) begin
                $display("%0t: proj_z expected %h actual %h", $time, e.qz, a.qz);
                errors++;
            end
        endfunction
    endclass

    localparam int NUM_RANDOM = 2000;
    localparam int CYCLE_LIMIT = 1000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [207:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [127:0] o_m_axis_tdata;

    closest_point_board board;
    bit                 calm;
    int                 cycles;

    closest_point_on_rotated_segment dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Gap length: mostly short, a few long, none while calm.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Drive one query and wait until its transfer completes.
    task automatic send_query(t_query q);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  = {1'b0, q.py, q.px, q.ang, q.len, q.cz, q.cy, q.cx};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_query(q);
        @(negedge i_clk);
    endtask

    task automatic send_fields(int cx, int cy, int cz, int unsigned len,
                               int unsigned ang, int px, int py);
        t_query q;
        q.cx  = cx;
        q.cy  = cy;
        q.cz  = cz;
        q.len = len[30:0];
        q.ang = ang[15:0];
        q.px  = px;
        q.py  = py;
        send_query(q);
    endtask

    // Random query: wide coordinates, or a point close to the center.
    function automatic t_query random_query();
        t_query q;
        int     span;
        q.cx  = $urandom;
        q.cy  = $urandom;
        q.cz  = $urandom;
        q.ang = 16'($urandom);
        case ($urandom_range(0, 3))
            0: q.len = 31'd0;
            1: q.len = 31'($urandom);
            default: q.len = 31'($urandom_range(0, 32'h00FF_FFFF));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            q.px = $urandom;
            q.py = $urandom;
        end else begin
            span = 1 << $urandom_range(4, 26);
            q.cx = $signed(q.cx) >>> $urandom_range(0, 6);
            q.cy = $signed(q.cy) >>> $urandom_range(0, 6);
            q.px = q.cx + $signed($urandom_range(0, 2 * span)) - span;
            q.py = q.cy + $signed($urandom_range(0, 2 * span)) - span;
        end
        return q;
    endfunction

    // Receiver stalls: mostly short, a few long, none while calm.
    always @(negedge i_clk) begin
        int p;
        p = $urandom_range(0, 99);
        if (!i_rst_n || calm) i_m_axis_tready = 1'b1;
        else if (p < 3) i_m_axis_tready = 1'b0;
        else if (p < 70) i_m_axis_tready = 1'b1;
        else i_m_axis_tready = ($urandom_range(0, 1) == 1);
    end

    // Check every answer transfer.
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            a.distance = o_m_axis_tdata[31:0];
            a.qx       = o_m_axis_tdata[63:32];
            a.qy       = o_m_axis_tdata[95:64];
            a.qz       = o_m_axis_tdata[127:96];
            board.check_answer(a);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        board           = new();
        cycles          = 0;
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: cardinal and odd angles, length extremes, field extremes.
        send_fields(0, 0, 0, 0, 0, 0, 0);
        send_fields(0, 0, 5, 32'h0002_0000, 0, 32'h0003_0000, 32'h0001_0000);
        send_fields(0, 0, 5, 32'h0002_0000, 16384, 32'h0001_0000, 32'h0003_0000);
        send_fields(0, 0, 5, 32'h0002_0000, 32768, -32'sh0003_0000, 0);
        send_fields(0, 0, 5, 32'h0002_0000, 49152, 0, -32'sh0005_0000);
        send_fields(100, -100, 7, 32'h0010_0000, 8192, 32'h0004_0000, 32'h0004_0000);
        send_fields(0, 0, 1, 32'h0004_0000, 65535, 32'h0001_0000, -32'sh0001_0000);
        send_fields(0, 0, 1, 32'h0004_0000, 16385, 0, 0);
        send_fields(0, 0, 1, 32'h7FFF_FFFF, 24576, 32'h0100_0000, 32'h0200_0000);
        // Far apart points drive the distance into saturation.
        send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                    32'h8000_0000, 32'h8000_0000);
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 12345,
                    32'h7FFF_FFFF, 32'h8000_0000);
        // Long segments near the edge push the closest point off range.
        send_fields(32'h7FFF_0000, 32'h7FFF_0000, 0, 32'h7FFF_FFFF, 8192,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_fields(32'h8001_0000, 32'h8001_0000, 0, 32'h7FFF_FFFF, 40960,
                    32'h8000_0000, 32'h8000_0000);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, -1, 32'h7FFF_FFFF, 57344,
                    32'h7FFF_FFFF, 32'h8000_0000);
        send_fields(-1, -1, -1, 32'h5555_5555, 43690, 32'h5555_5555, 32'hAAAA_AAAA);
        send_fields(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA, 21845,
                    -1, -1);
        send_fields(0, 0, 0, 1, 32767, 1, 1);
        send_fields(0, 0, 0, 1, 32769, -1, 0);

        // Random part, with calm stretches that have no idling at all.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 250 == 0) calm = ($urandom_range(0, 2) == 0);
            send_query(random_query());
        end
        i_s_axis_tvalid = 1'b0;
        calm = 1'b0;

        // Drain, then allow the pipeline depth to pass.
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
